FILE: src/dual_queue_shared_buffer_top_macros.svh
`ifndef DUAL_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH
`define DUAL_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DQSB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqsb check failed");

// next-cycle implication, sampled on clk, off during reset
`define DQSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqsb check failed");

`endif

FILE: src/dqsb_pkg.sv
package dqsb_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_ONE = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_ONE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_TWO = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_TWO  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic resp;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: src/dual_queue_shared_buffer_top.sv
// Each request passes through accept, pointer update and RAM access, and result load;
// a new request is accepted only after the previous result is loaded, and a stalled
// output holds the request in the result stage.
// Reset (rst_n, async, active low): queue one pointers to -1, queue two pointers
// to DEPTH, controller idle, no result pending. Storage is not cleared.
`include "dual_queue_shared_buffer_top_macros.svh"

module dual_queue_shared_buffer_top #(
    parameter int DEPTH = dqsb_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dqsb_pkg::OP_W-1:0]          op,
    input  logic signed [dqsb_pkg::DATA_W-1:0] push_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [dqsb_pkg::DATA_W-1:0] pop_value,
    output logic [dqsb_pkg::STATUS_W-1:0]      status
);
    import dqsb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idle;

    dqsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    dqsb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    `DQSB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready && cmd.exec)
    `DQSB_ASSERT_NOW(a_fail_zero, out_valid && status != STATUS_OK, pop_value == '0)
    `DQSB_ASSERT_NOW(a_status_code, out_valid, status <= STATUS_EMPTY)
    `DQSB_ASSERT_NOW(a_resp_free, cmd.resp, !(out_valid && !out_ready) && !idle)

endmodule

FILE: src/dqsb_ctrl.sv
module dqsb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dqsb_pkg::dp_stat_t stat,
    output dqsb_pkg::dp_cmd_t  cmd,
    output logic              idle
);
    import dqsb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        idle     = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                idle     = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_RESP:
            begin
                cmd.resp = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/dqsb_datapath.sv
module dqsb_datapath #(
    parameter int DEPTH = dqsb_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dqsb_pkg::dp_cmd_t                      cmd,
    output dqsb_pkg::dp_stat_t                     stat,
    input  logic [dqsb_pkg::OP_W-1:0]              op,
    input  logic signed [dqsb_pkg::DATA_W-1:0]     push_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dqsb_pkg::DATA_W-1:0]     pop_value,
    output logic [dqsb_pkg::STATUS_W-1:0]          status
);
    import dqsb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1) + 1;

    localparam logic signed [PW-1:0] P_ONE   = PW'(1);
    localparam logic signed [PW-1:0] P_NEG   = PW'(-1);
    localparam logic signed [PW-1:0] P_ZERO  = PW'(0);
    localparam logic signed [PW-1:0] P_TOP   = PW'(DEPTH);
    localparam logic signed [PW-1:0] P_TOPM1 = PW'(DEPTH - 1);

    logic [DATA_W-1:0] storage [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [DATA_W-1:0]      val_reg, val_next;
    logic signed [PW-1:0]   front_one_reg, front_one_next;
    logic signed [PW-1:0]   rear_one_reg, rear_one_next;
    logic signed [PW-1:0]   front_two_reg, front_two_next;
    logic signed [PW-1:0]   rear_two_reg, rear_two_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   res_pop_reg, res_pop_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      pop_value_reg, pop_value_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic signed [PW-1:0]   rear_one_inc;
    logic signed [PW-1:0]   rear_two_dec;
    logic                   full;

    assign rear_one_inc = rear_one_reg + P_ONE;
    assign rear_two_dec = rear_two_reg - P_ONE;
    assign full         = (rear_one_inc == rear_two_reg);

    always_comb
    begin
        op_next         = op_reg;
        val_next        = val_reg;
        front_one_next  = front_one_reg;
        rear_one_next   = rear_one_reg;
        front_two_next  = front_two_reg;
        rear_two_next   = rear_two_reg;
        res_status_next = res_status_reg;
        res_pop_next    = res_pop_reg;
        wr_en           = 1'b0;
        wr_addr         = rear_one_inc[AW-1:0];
        rd_addr         = front_one_reg[AW-1:0];

        if (cmd.load)
        begin
            op_next  = op;
            val_next = push_value;
        end

        if (cmd.exec)
        begin
            res_status_next = STATUS_OK;
            res_pop_next    = 1'b0;
            case (op_reg)
                OP_PUSH_ONE:
                begin
                    if (full)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        if (front_one_reg == P_NEG)
                        begin
                            front_one_next = P_ZERO;
                        end
                        rear_one_next = rear_one_inc;
                        wr_en         = 1'b1;
                        wr_addr       = rear_one_inc[AW-1:0];
                    end
                end
                OP_POP_ONE:
                begin
                    if (front_one_reg == P_NEG || front_one_reg > rear_one_reg)
                    begin
                        res_status_next = STATUS_EMPTY;
                        front_one_next  = P_NEG;
                        rear_one_next   = P_NEG;
                    end
                    else
                    begin
                        res_pop_next   = 1'b1;
                        rd_addr        = front_one_reg[AW-1:0];
                        front_one_next = front_one_reg + P_ONE;
                    end
                end
                OP_PUSH_TWO:
                begin
                    if (full)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        if (front_two_reg == P_TOP)
                        begin
                            front_two_next = P_TOPM1;
                        end
                        rear_two_next = rear_two_dec;
                        wr_en         = 1'b1;
                        wr_addr       = rear_two_dec[AW-1:0];
                    end
                end
                OP_POP_TWO:
                begin
                    if (front_two_reg == P_TOP || front_two_reg < rear_two_reg)
                    begin
                        res_status_next = STATUS_EMPTY;
                        front_two_next  = P_TOP;
                        rear_two_next   = P_TOP;
                    end
                    else
                    begin
                        res_pop_next   = 1'b1;
                        rd_addr        = front_two_reg[AW-1:0];
                        front_two_next = front_two_reg - P_ONE;
                    end
                end
                default:
                begin
                    res_status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        if (cmd.resp)
        begin
            out_valid_next = 1'b1;
            pop_value_next = res_pop_reg ? rd_data_reg : '0;
            status_next    = res_status_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // read data is held until the result stage loads it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            storage[wr_addr] <= val_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= storage[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_one_reg <= P_NEG;
            rear_one_reg  <= P_NEG;
            front_two_reg <= P_TOP;
            rear_two_reg  <= P_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_one_reg <= front_one_next;
            rear_one_reg  <= rear_one_next;
            front_two_reg <= front_two_next;
            rear_two_reg  <= rear_two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_pop_reg    <= res_pop_next;
        pop_value_reg  <= pop_value_next;
        status_reg     <= status_next;
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign pop_value     = pop_value_reg;
    assign status        = status_reg;

endmodule

FILE: sim/dqsb_result_checker.sv
`timescale 1ns / 1ps

module dqsb_result_checker #(
    parameter int DEPTH = dqsb_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [dqsb_pkg::OP_W-1:0]           op,
    input  logic signed [dqsb_pkg::DATA_W-1:0]  push_value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [dqsb_pkg::DATA_W-1:0]  pop_value,
    input  logic [dqsb_pkg::STATUS_W-1:0]       status,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked,
    output int                                  full_seen,
    output int                                  empty_seen
);
    import dqsb_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [STATUS_W-1:0]      status;
    } queue_result_t;

    logic signed [DATA_W-1:0] slots [DEPTH];
    int q1_head;
    int q1_tail;
    int q2_head;
    int q2_tail;

    queue_result_t expected_results [$];
    queue_result_t predicted;
    queue_result_t oldest;

    function automatic void apply_queue_op(
        input  logic [OP_W-1:0]          code,
        input  logic signed [DATA_W-1:0] value,
        output queue_result_t            res
    );
        res.pop_value = '0;
        res.status    = STATUS_OK;
        case (code)
            OP_PUSH_ONE:
            begin
                if (q1_tail + 1 == q2_tail)
                    res.status = STATUS_FULL;
                else
                begin
                    if (q1_head == -1)
                        q1_head = 0;
                    q1_tail++;
                    slots[q1_tail] = value;
                end
            end
            OP_POP_ONE:
            begin
                if (q1_head == -1 || q1_head > q1_tail)
                begin
                    res.status = STATUS_EMPTY;
                    q1_head    = -1;
                    q1_tail    = -1;
                end
                else
                begin
                    res.pop_value = slots[q1_head];
                    q1_head++;
                end
            end
            OP_PUSH_TWO:
            begin
                if (q1_tail + 1 == q2_tail)
                    res.status = STATUS_FULL;
                else
                begin
                    if (q2_head == DEPTH)
                        q2_head = DEPTH - 1;
                    q2_tail--;
                    slots[q2_tail] = value;
                end
            end
            default:
            begin
                if (q2_head == DEPTH || q2_head < q2_tail)
                begin
                    res.status = STATUS_EMPTY;
                    q2_head    = DEPTH;
                    q2_tail    = DEPTH;
                end
                else
                begin
                    res.pop_value = slots[q2_head];
                    q2_head--;
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slots[i] = '0;
            q1_head    = -1;
            q1_tail    = -1;
            q2_head    = DEPTH;
            q2_tail    = DEPTH;
            expected_results.delete();
            fail_count = 0;
            checked    = 0;
            full_seen  = 0;
            empty_seen = 0;
            pending    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_queue_op(op, push_value, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: pop_value %0d status %0d",
                           pop_value, status);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    checked++;
                    if (oldest.status == STATUS_FULL)
                        full_seen++;
                    if (oldest.status == STATUS_EMPTY)
                        empty_seen++;
                    if (pop_value !== oldest.pop_value)
                    begin
                        $error("pop_value: expected %0d, got %0d", oldest.pop_value, pop_value);
                        fail_count++;
                    end
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import dqsb_pkg::*;

    localparam int RANDOM_REQUESTS = 400;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          op         = OP_PUSH_ONE;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    int send_idle_pct = 30;
    int recv_idle_pct = 48;
    int sent          = 0;
    int per_op [4];

    dual_queue_shared_buffer_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    dqsb_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_seen  (full_seen),
        .empty_seen (empty_seen)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // idling mix: sender 30 / receiver 48, then swapped, then none
    task automatic issue_request(input logic [OP_W-1:0] code,
                                 input logic signed [DATA_W-1:0] value);
        if (sent < 140)
        begin
            send_idle_pct = 30;
            recv_idle_pct = 48;
        end
        else if (sent < 280)
        begin
            send_idle_pct = 48;
            recv_idle_pct = 30;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        push_value <= value;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sent++;
        per_op[code]++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                3: return 32'shFFFF_FFFF;
                default: return 32'sh0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    // mix 0: balanced, 1: push heavy, 2: pop heavy
    function automatic logic [OP_W-1:0] pick_op(input int mix);
        int push_pct;
        logic is_push;
        logic second;
        push_pct = (mix == 1) ? 75 : (mix == 2) ? 25 : 50;
        is_push  = ($urandom_range(99) < push_pct);
        second   = 1'($urandom_range(1));
        if (is_push)
            return second ? OP_PUSH_TWO : OP_PUSH_ONE;
        return second ? OP_POP_TWO : OP_POP_ONE;
    endfunction

    initial
    begin
        int mix;
        mix = 0;
        foreach (per_op[i])
            per_op[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, first pop of each queue, empty pops
        issue_request(OP_PUSH_ONE, 32'sh7FFF_FFFF);
        issue_request(OP_PUSH_TWO, 32'sh8000_0000);
        issue_request(OP_POP_ONE, 32'sh0000_0000);
        issue_request(OP_POP_TWO, 32'shFFFF_FFFF);
        issue_request(OP_POP_ONE, 32'sh0000_0000);
        issue_request(OP_POP_TWO, 32'sh0000_0000);
        // fill the shared array from both ends, then push into full
        for (int i = 0; i < 8; i++)
        begin
            issue_request(OP_PUSH_ONE, $urandom);
            issue_request(OP_PUSH_TWO, $urandom);
        end
        issue_request(OP_PUSH_ONE, 32'sh5555_5555);
        issue_request(OP_PUSH_TWO, 32'shAAAA_AAAA);
        issue_request(OP_POP_ONE, 32'sh0000_0000);
        issue_request(OP_POP_TWO, 32'sh0000_0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 8 == 0)
                mix = $urandom_range(2);
            issue_request(pick_op(mix), pick_value());
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests: %0d push one, %0d pop one, %0d push two, %0d pop two",
                 sent, per_op[OP_PUSH_ONE], per_op[OP_POP_ONE],
                 per_op[OP_PUSH_TWO], per_op[OP_POP_TWO]);
        $display("Compared %0d results, %0d full pushes and %0d empty pops among them",
                 checked, full_seen, empty_seen);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: dual_queue_shared_buffer_top.f
+incdir+src
src/dqsb_pkg.sv
src/dqsb_ctrl.sv
src/dqsb_datapath.sv
src/dual_queue_shared_buffer_top.sv
sim/dqsb_result_checker.sv
sim/tb.sv
